// ===== design/assert_macros.svh =====
// Assertion macros shared by the affine transform RTL.
// Holds only macro definitions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("concurrent assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("concurrent assertion failed");

`endif

// ===== design/amt_pkg.sv =====
// Shared types, widths and mode codes for the affine matrix transform.
// No dependencies.
package amt_pkg;

  localparam int DATA_W    = 32;
  localparam int DIM       = 3;
  localparam int ENTRIES   = DIM * DIM;
  localparam int MODE_W    = 3;
  localparam int IDX_W     = 4;
  localparam int FRAC_BITS = 16;

  localparam logic [MODE_W-1:0] MODE_IDENTITY  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCALE     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TRANSLATE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_VECTOR    = 3'd4;

  typedef logic [DATA_W-1:0] word_t;
  typedef word_t [ENTRIES-1:0] matrix_t;
  typedef word_t [DIM-1:0] row_t;

  typedef struct packed {
    logic              en;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  idx;
  } mat_upd_t;

endpackage

// ===== design/amt_mac_array.sv =====
// Nine fixed-point multipliers and three row adders for the affine transform.
// Depends on amt_pkg.
module amt_mac_array #(
  parameter int FracBits = amt_pkg::FRAC_BITS
) (
  input  amt_pkg::matrix_t matrix_i,
  input  amt_pkg::word_t   arg_x_i,
  input  amt_pkg::word_t   arg_y_i,
  input  amt_pkg::word_t   arg_z_i,
  input  logic             use_p2_i,
  output amt_pkg::matrix_t prod_o,
  output amt_pkg::row_t    rsum_o
);

  amt_pkg::row_t arg_vec;

  assign arg_vec = {arg_z_i, arg_y_i, arg_x_i};

  for (genvar r = 0; r < amt_pkg::DIM; r++) begin : g_row
    for (genvar c = 0; c < amt_pkg::DIM; c++) begin : g_col
      logic signed [2*amt_pkg::DATA_W-1:0] full;
      assign full = $signed(matrix_i[r*amt_pkg::DIM+c]) * $signed(arg_vec[c]);
      assign prod_o[r*amt_pkg::DIM+c] = full[FracBits +: amt_pkg::DATA_W];
    end
    assign rsum_o[r] = prod_o[r*amt_pkg::DIM] + prod_o[r*amt_pkg::DIM+1]
                     + (use_p2_i ? prod_o[r*amt_pkg::DIM+2]
                                 : matrix_i[r*amt_pkg::DIM+2]);
  end

endmodule

// ===== design/amt_matrix_reg.sv =====
// Matrix register of the affine transform with identity reset and updates.
// Depends on amt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module amt_matrix_reg #(
  parameter int FracBits = amt_pkg::FRAC_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  amt_pkg::mat_upd_t upd_i,
  input  amt_pkg::word_t   wdata_i,
  input  amt_pkg::matrix_t prod_i,
  input  amt_pkg::row_t    rsum_i,
  output amt_pkg::matrix_t matrix_o
);

  localparam amt_pkg::word_t OneVal = amt_pkg::word_t'(1) << FracBits;

  amt_pkg::matrix_t matrix_d, matrix_q, ident;

  always_comb begin
    ident = '0;
    for (int r = 0; r < amt_pkg::DIM; r++) begin
      ident[r*amt_pkg::DIM+r] = OneVal;
    end
  end

  always_comb begin
    matrix_d = matrix_q;
    if (upd_i.en) begin
      case (upd_i.mode)
        amt_pkg::MODE_IDENTITY: begin
          matrix_d = ident;
        end
        amt_pkg::MODE_WRITE: begin
          if (upd_i.idx < amt_pkg::IDX_W'(amt_pkg::ENTRIES)) begin
            matrix_d[upd_i.idx] = wdata_i;
          end
        end
        amt_pkg::MODE_SCALE: begin
          for (int r = 0; r < amt_pkg::DIM; r++) begin
            matrix_d[r*amt_pkg::DIM]   = prod_i[r*amt_pkg::DIM];
            matrix_d[r*amt_pkg::DIM+1] = prod_i[r*amt_pkg::DIM+1];
          end
        end
        amt_pkg::MODE_TRANSLATE: begin
          for (int r = 0; r < amt_pkg::DIM; r++) begin
            matrix_d[r*amt_pkg::DIM+2] = rsum_i[r];
          end
        end
        default: begin
          matrix_d = matrix_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q <= ident;
    end else begin
      matrix_q <= matrix_d;
    end
  end

  assign matrix_o = matrix_q;

  `AMT_ASSERT_NEXT(a_ident_load, clk_i, rst_ni,
    upd_i.en && upd_i.mode == amt_pkg::MODE_IDENTITY,
    matrix_q[0] == OneVal && matrix_q[1] == '0 && matrix_q[8] == OneVal)
  `AMT_ASSERT_NEXT(a_bad_idx_keeps, clk_i, rst_ni,
    upd_i.en && upd_i.mode == amt_pkg::MODE_WRITE && upd_i.idx >= 4'd9,
    $stable(matrix_q))

endmodule

// ===== design/affine_matrix_transform.sv =====
// Top level of the 3x3 fixed-point affine transform.
// Depends on amt_pkg, amt_mac_array, amt_matrix_reg and assert_macros.svh.
//
// Usage: items enter on the in channel (in_valid_i/in_ready_o) with a mode and up to
// three 16.16 arguments. Identity, write, scale and translate items update the held
// matrix and produce no word. A vector item produces one word on the out channel
// (out_valid_o/out_ready_i) holding the transformed x, y and z.
// An accepted item waits in the input register while the nine multipliers and row
// adders work; as it leaves, a vector result is loaded into the output register and
// leaves from there. A matrix update is seen by the very next item.
// Throughput: one item per cycle, set by the single pass through the multiplier array,
// except when the receiver stalls with a result waiting: a following vector item holds
// in the input register and in_ready_o drops; matrix updates still retire every cycle.
// Reset loads the identity matrix and empties both registers.
`include "assert_macros.svh"

module affine_matrix_transform #(
  parameter int FracBits = amt_pkg::FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [amt_pkg::MODE_W-1:0]          mode_i,
  input  logic [amt_pkg::IDX_W-1:0]           entry_index_i,
  input  logic signed [amt_pkg::DATA_W-1:0]   arg_x_i,
  input  logic signed [amt_pkg::DATA_W-1:0]   arg_y_i,
  input  logic signed [amt_pkg::DATA_W-1:0]   arg_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [amt_pkg::DATA_W-1:0]   out_x_o,
  output logic signed [amt_pkg::DATA_W-1:0]   out_y_o,
  output logic signed [amt_pkg::DATA_W-1:0]   out_z_o
);

  logic                       s1_valid_q, s1_valid_d;
  logic [amt_pkg::MODE_W-1:0] mode_q;
  logic [amt_pkg::IDX_W-1:0]  idx_q;
  amt_pkg::word_t             ax_q, ay_q, az_q;
  logic                       out_valid_q, out_valid_d;
  amt_pkg::row_t              out_q;

  logic             in_fire, s1_is_vec, s1_fire, out_load;
  amt_pkg::matrix_t matrix, prod;
  amt_pkg::row_t    rsum;
  amt_pkg::mat_upd_t upd;

  assign s1_is_vec  = mode_q == amt_pkg::MODE_VECTOR;
  assign s1_fire    = s1_valid_q && (!s1_is_vec || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = s1_fire && s1_is_vec;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_fire);
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  assign upd.en   = s1_fire;
  assign upd.mode = mode_q;
  assign upd.idx  = idx_q;

  amt_mac_array #(
    .FracBits(FracBits)
  ) u_mac (
    .matrix_i(matrix),
    .arg_x_i (ax_q),
    .arg_y_i (ay_q),
    .arg_z_i (az_q),
    .use_p2_i(s1_is_vec),
    .prod_o  (prod),
    .rsum_o  (rsum)
  );

  amt_matrix_reg #(
    .FracBits(FracBits)
  ) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .wdata_i (ax_q),
    .prod_i  (prod),
    .rsum_i  (rsum),
    .matrix_o(matrix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= mode_i;
      idx_q  <= entry_index_i;
      ax_q   <= amt_pkg::word_t'(arg_x_i);
      ay_q   <= amt_pkg::word_t'(arg_y_i);
      az_q   <= amt_pkg::word_t'(arg_z_i);
    end
    if (out_load) begin
      out_q <= rsum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = $signed(out_q[0]);
  assign out_y_o     = $signed(out_q[1]);
  assign out_z_o     = $signed(out_q[2]);

  `AMT_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !in_ready_o,
    s1_valid_q && s1_is_vec && out_valid_q && !out_ready_i)
  `AMT_ASSERT_IMPL(a_update_no_stall, clk_i, rst_ni, s1_valid_q && !s1_is_vec, s1_fire)
  `AMT_ASSERT_NEXT(a_vec_gives_word, clk_i, rst_ni, s1_fire && s1_is_vec, out_valid_q)

endmodule
